@@ sv/spi_master_core_unit_macros.svh @@
// Assertion macros for the SPI master core unit.
// Expects a clock named clk and a synchronous reset named rst in the using scope.
`ifndef SPI_MASTER_CORE_UNIT_MACROS_SVH
`define SPI_MASTER_CORE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smc check failed");

// Next-cycle implication, disabled while reset is high.
`define SMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smc check failed");

`endif

@@ sv/smc_pkg.sv @@
// Package for the SPI master core unit: word kinds, register map, widths, result type.
// No dependencies.
package smc_pkg;

  localparam int NUM_SLAVES = 32;
  localparam int DATA_BITS  = 8;

  // Input word kinds (carried on s_tuser)
  localparam logic [2:0] KIND_SELECT = 3'd0;
  localparam logic [2:0] KIND_DC     = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_POLARITY = 2'd0;
  localparam logic [1:0] REG_PHASE    = 2'd1;
  localparam logic [1:0] REG_MODULUS  = 2'd2;

  localparam logic [15:0] MODULUS_RESET = 16'd4;

  // Last half-period index of a transfer (odd, 2*DATA_BITS-1)
  localparam logic [4:0] LAST_HALF = 5'(2 * DATA_BITS - 1);

  typedef struct packed {
    logic                  dc_level;
    logic [NUM_SLAVES-1:0] select_lines;
    logic                  mosi_level;
    logic                  sclk_level;
    logic [DATA_BITS-1:0]  received_byte;
    logic                  ready_res;
  } res_t;

endpackage

@@ sv/spi_master_core_unit.sv @@
// SPI master core unit, modes 0 to 3, 8-bit MSB-first full-duplex transfers.
// Depends on smc_pkg and spi_master_core_unit_macros.svh.
// The result word of an accepted input word is loaded into the output register in the next cycle.
// Throughput: one word per cycle unless stalled; update and result fit in one register pass.
// s_tready drops only while a result waits in the output register and m_tready is low.
// Reset (rst, synchronous, active high): idle, counters and shift registers cleared, all
// selects high, dc low, polarity 0, phase 0, half-period modulus 4, output register empty.
`include "spi_master_core_unit_macros.svh"

module spi_master_core_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] write_value, [32] miso_bit, rest zero
  input  logic [2:0]  s_tuser,   // [2:0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [0] ready_res, [8:1] received_byte, [9] sclk_level,
                                 // [10] mosi_level, [42:11] select_lines, [43] dc_level
);
  import smc_pkg::*;

  // configuration registers
  logic        clock_polarity;
  logic        clock_phase;
  logic [15:0] half_period_modulus;

  // core state
  logic [15:0]           divider_count, divider_count_next;
  logic [4:0]            edge_count, edge_count_next;
  logic [DATA_BITS-1:0]  transmit_shift, transmit_shift_next;
  logic [DATA_BITS-1:0]  receive_shift, receive_shift_next;
  logic [DATA_BITS-1:0]  received_hold, received_hold_next;
  logic                  busy_flag, busy_flag_next;
  logic [NUM_SLAVES-1:0] select_vector, select_vector_next;
  logic                  dc_pin, dc_pin_next;

  // output register
  res_t result, result_next;

  logic        s_accept;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [2:0]  kind;
  logic [31:0] write_value;
  logic        miso_bit;
  logic [4:0]  half_index;
  logic        pulse;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_comb begin
    unique case (cfg_index)
      REG_POLARITY: prdata = {31'b0, clock_polarity};
      REG_PHASE:    prdata = {31'b0, clock_phase};
      REG_MODULUS:  prdata = {16'b0, half_period_modulus};
      default:      prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_polarity      <= 1'b0;
      clock_phase         <= 1'b0;
      half_period_modulus <= MODULUS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POLARITY: clock_polarity      <= pwdata[0];
        REG_PHASE:    clock_phase         <= pwdata[0];
        REG_MODULUS:  half_period_modulus <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Output register acts as the only stage; it can refill while it drains.
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  assign kind        = s_tuser;
  assign write_value = s_tdata[31:0];
  assign miso_bit    = s_tdata[32];

  // Half-period index within the data phase; phase 1 spends edge 0 as a lead-in.
  assign half_index = edge_count - {4'b0, clock_phase};

  always_comb begin
    divider_count_next  = divider_count;
    edge_count_next     = edge_count;
    transmit_shift_next = transmit_shift;
    receive_shift_next  = receive_shift;
    received_hold_next  = received_hold;
    busy_flag_next      = busy_flag;
    select_vector_next  = select_vector;
    dc_pin_next         = dc_pin;

    unique case (kind)
      KIND_SELECT: select_vector_next = write_value[NUM_SLAVES-1:0];
      KIND_DC:     dc_pin_next = write_value[0];
      KIND_DATA: begin
        // a data word while busy is dropped
        if (!busy_flag) begin
          transmit_shift_next = write_value[DATA_BITS-1:0];
          receive_shift_next  = '0;
          divider_count_next  = '0;
          edge_count_next     = '0;
          busy_flag_next      = 1'b1;
        end
      end
      KIND_TICK: begin
        if (busy_flag) begin
          if (divider_count >= half_period_modulus) begin
            divider_count_next = '0;
            if (clock_phase && edge_count == 5'd0) begin
              edge_count_next = 5'd1;
            end else if (!half_index[0]) begin
              // sampling edge
              receive_shift_next = {receive_shift[DATA_BITS-2:0], miso_bit};
              edge_count_next    = edge_count + 5'd1;
            end else if (half_index >= LAST_HALF) begin
              // last half period: latch the byte and go idle
              received_hold_next = receive_shift;
              busy_flag_next     = 1'b0;
              edge_count_next    = '0;
            end else begin
              // shifting edge
              transmit_shift_next = {transmit_shift[DATA_BITS-2:0], 1'b0};
              edge_count_next     = edge_count + 5'd1;
            end
          end else begin
            divider_count_next = divider_count + 16'd1;
          end
        end
      end
      default: ;  // read and unused kinds change nothing
    endcase
  end

  // SCLK is away from idle on odd half-period counts in either phase; in phase 1
  // count 0 is the lead-in, so the first pulse still comes one half period later.
  always_comb begin
    pulse = 1'b0;
    if (busy_flag_next) begin
      if (clock_phase) pulse = edge_count_next[0];
      else             pulse = edge_count_next[0];
    end
  end

  always_comb begin
    result_next.ready_res     = !busy_flag_next;
    result_next.received_byte = received_hold_next;
    result_next.sclk_level    = clock_polarity ^ pulse;
    result_next.mosi_level    = transmit_shift_next[DATA_BITS-1];
    result_next.select_lines  = select_vector_next;
    result_next.dc_level      = dc_pin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count  <= '0;
      edge_count     <= '0;
      transmit_shift <= '0;
      receive_shift  <= '0;
      received_hold  <= '0;
      busy_flag      <= 1'b0;
      select_vector  <= '1;
      dc_pin         <= 1'b0;
    end else if (s_accept) begin
      divider_count  <= divider_count_next;
      edge_count     <= edge_count_next;
      transmit_shift <= transmit_shift_next;
      receive_shift  <= receive_shift_next;
      received_hold  <= received_hold_next;
      busy_flag      <= busy_flag_next;
      select_vector  <= select_vector_next;
      dc_pin         <= dc_pin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      result <= result_next;
    end
  end

  assign m_tdata = {4'b0, result};

  // idle means counters at rest
  `SMC_ASSERT_NOW(a_idle_rest, !busy_flag, edge_count == 5'd0 && divider_count == 16'd0)
  // a waiting result reports the busy state the core holds now
  `SMC_ASSERT_NOW(a_ready_tracks_busy, m_tvalid, result.ready_res == !busy_flag)
  // every accepted word produces a result word
  `SMC_ASSERT_NEXT(a_result_follows, s_accept, m_tvalid)
  // a stalled result blocks input
  `SMC_ASSERT_NOW(a_stall_blocks, m_tvalid && !m_tready, !s_tready)

endmodule
